/* sv/svct_pkg.sv */
// Shared constants and types for the sorted value count table.
package svct_pkg;

  localparam int CELLS = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int OCC_WIDTH = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic                    occ;
    logic [VALUE_WIDTH-1:0]  value;
    logic [COUNT_WIDTH-1:0]  count;
  } cell_t;

  typedef struct packed {
    logic                    load;
    logic                    shift;
    logic                    match_any;
    logic                    full;
    logic [VALUE_WIDTH-1:0]  sample;
  } ctrl_t;

  function automatic logic [OCC_WIDTH-1:0] clamp_count(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    if (wide > 64'({OCC_WIDTH{1'b1}})) begin
      return {OCC_WIDTH{1'b1}};
    end
    return wide[OCC_WIDTH-1:0];
  endfunction

endpackage

/* sv/svct_cell.sv */
// One cell of the sorted chain: holds a value and its count.
module svct_cell (
  input  logic            clk,
  input  logic            rst,
  input  svct_pkg::ctrl_t ctrl,
  input  svct_pkg::cell_t prev_cell,
  input  logic            prev_above,
  input  svct_pkg::cell_t next_cell,
  output svct_pkg::cell_t cur,
  output logic            above,
  output logic            match
);

  svct_pkg::cell_t cur_next;

  assign above = !cur.occ || ($signed(cur.value) > $signed(ctrl.sample));
  assign match = cur.occ && (cur.value == ctrl.sample);

  always_comb begin
    cur_next = cur;
    if (ctrl.load) begin
      if (ctrl.match_any) begin
        if (match && (cur.count != svct_pkg::COUNT_MAX)) begin
          cur_next.count = cur.count + 1'b1;
        end
      end else if (!ctrl.full && above) begin
        if (prev_above) begin
          cur_next = prev_cell;
        end else begin
          cur_next.occ = 1'b1;
          cur_next.value = ctrl.sample;
          cur_next.count = svct_pkg::COUNT_WIDTH'(1);
        end
      end
    end else if (ctrl.shift) begin
      cur_next = next_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.occ <= 1'b0;
    end else begin
      cur.occ <= cur_next.occ;
    end
    cur.value <= cur_next.value;
    cur.count <= cur_next.count;
  end

endmodule

/* sv/sorted_value_count_table.sv */
// Each sample is registered into the cell chain as it is accepted, one per cycle while loading.
// After the sample flagged tlast, results follow from the next cycle, one per cycle while m_tready is high.
// No sample is accepted while the distinct values are being emitted.
// Synchronous reset empties every cell and clears the overflow flag.
module sorted_value_count_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tlast,   // end_of_set
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] distinct_value, [47:32] occurrences
  output logic        m_tuser,   // table_overflow
  output logic        m_tlast    // final_entry
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic overflow;
  logic overflow_next;

  svct_pkg::ctrl_t ctrl;
  svct_pkg::cell_t cells [svct_pkg::CELLS];
  logic [svct_pkg::CELLS-1:0] above;
  logic [svct_pkg::CELLS-1:0] match;

  logic in_take;
  logic out_take;
  logic last_out;

  assign s_tready = (state == ST_LOAD);
  assign in_take = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_EMIT);
  assign out_take = m_tvalid && m_tready;
  assign last_out = !cells[1].occ;

  assign ctrl.load = in_take;
  assign ctrl.shift = out_take;
  assign ctrl.match_any = |match;
  assign ctrl.full = cells[svct_pkg::CELLS-1].occ;
  assign ctrl.sample = s_tdata;

  for (genvar i = 0; i < svct_pkg::CELLS; i++) begin : g_cell
    svct_pkg::cell_t prev_c;
    svct_pkg::cell_t next_c;
    logic            prev_a;
    if (i == 0) begin : g_first
      assign prev_c = '0;
      assign prev_a = 1'b0;
    end else begin : g_mid
      assign prev_c = cells[i-1];
      assign prev_a = above[i-1];
    end
    if (i == svct_pkg::CELLS - 1) begin : g_last
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end
    svct_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_cell  (prev_c),
      .prev_above (prev_a),
      .next_cell  (next_c),
      .cur        (cells[i]),
      .above      (above[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    state_next = state;
    overflow_next = overflow;
    case (state)
      ST_LOAD: begin
        if (in_take) begin
          if (!ctrl.match_any && ctrl.full) begin
            overflow_next = 1'b1;
          end
          if (s_tlast) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_take && last_out) begin
          state_next = ST_LOAD;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      overflow <= overflow_next;
    end
  end

  assign m_tdata = {svct_pkg::clamp_count(cells[0].count), cells[0].value};
  assign m_tuser = overflow;
  assign m_tlast = last_out;

endmodule

/* sv/svct_checker.sv */
// Port-level checks for the sorted value count table, bound to the top level.
module svct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("Input accepted while results are pending.");

  a_emit_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("No result after the closing transaction.");

  a_ready_after_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("Block did not return to loading after the final result.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("Stalled result changed.");

endmodule

bind sorted_value_count_table svct_checker u_svct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* bench/testbench.sv */
// Self-checking testbench for the sorted value count table, with its own tabulating predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int RUN_LIMIT = 1_000_000;
  localparam int CALM_TAIL = 40;

  typedef struct {
    logic [svct_pkg::VALUE_WIDTH-1:0] value;
    bit                               closes;
    bit                               hold;
    bit                               steady;
  } sample_item_t;

  typedef struct {
    logic [svct_pkg::VALUE_WIDTH-1:0] value;
    logic [svct_pkg::OCC_WIDTH-1:0]   occ;
    logic                             dropped;
    logic                             final_one;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  sample_item_t sample_queue[$];
  table_row_t   table_due[$];

  logic signed [svct_pkg::VALUE_WIDTH-1:0] tab_value[svct_pkg::CELLS];
  logic [svct_pkg::COUNT_WIDTH-1:0]        tab_count[svct_pkg::CELLS];
  int                                      tab_used = 0;
  bit                                      tab_dropped = 1'b0;

  int error_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;

  sorted_value_count_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    error_count++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // Places one sample into the sorted table; a closing sample dumps the table as results.
  task automatic tally_sample(input logic signed [svct_pkg::VALUE_WIDTH-1:0] v,
                              input bit closes);
    int pos;
    int i;
    table_row_t row;
    pos = 0;
    while (pos < tab_used && tab_value[pos] < v) pos++;
    if (pos < tab_used && tab_value[pos] == v) begin
      if (tab_count[pos] != svct_pkg::COUNT_MAX) tab_count[pos]++;
    end else if (tab_used >= svct_pkg::CELLS) begin
      tab_dropped = 1'b1;
    end else begin
      for (i = tab_used; i > pos; i--) begin
        tab_value[i] = tab_value[i-1];
        tab_count[i] = tab_count[i-1];
      end
      tab_value[pos] = v;
      tab_count[pos] = svct_pkg::COUNT_WIDTH'(1);
      tab_used++;
    end
    if (closes) begin
      for (i = 0; i < tab_used; i++) begin
        row.value = tab_value[i];
        row.occ = svct_pkg::clamp_count(tab_count[i]);
        row.dropped = tab_dropped;
        row.final_one = (i == tab_used - 1);
        table_due.push_back(row);
      end
      tab_used = 0;
      tab_dropped = 1'b0;
    end
  endtask

  task automatic add_sample(input logic [31:0] v, input bit closes, input bit hold = 1'b0,
                            input bit steady = 1'b0);
    sample_item_t item;
    item.value = v;
    item.closes = closes;
    item.hold = hold;
    item.steady = steady;
    sample_queue.push_back(item);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2, 3, 4, 5: return 32'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin : feed
    sample_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (sample_queue.size() == 0 ||
                   (sample_queue[0].hold && (table_due.size() != 0 || s_tvalid))) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = sample_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.value;
        s_tlast <= nxt.closes;
        if (!nxt.steady && sample_queue.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (sample_queue.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin : watch
    table_row_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) tally_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (table_due.size() == 0) begin
          flag_mismatch("unexpected transaction", m_tdata, '0);
        end else begin
          want = table_due.pop_front();
          if (m_tdata[31:0] !== want.value) begin
            flag_mismatch("distinct_value", 48'(m_tdata[31:0]), 48'(want.value));
          end
          if (m_tdata[47:32] !== want.occ) begin
            flag_mismatch("occurrences", 48'(m_tdata[47:32]), 48'(want.occ));
          end
          if (m_tuser !== want.dropped) begin
            flag_mismatch("table_overflow", 48'(m_tuser), 48'(want.dropped));
          end
          if (m_tlast !== want.final_one) begin
            flag_mismatch("final_entry", 48'(m_tlast), 48'(want.final_one));
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int i;
    int len;
    int total;
    bit hold;
    bit big;

    add_sample(32'h8000_0000, 1'b1);
    add_sample(32'h7fff_ffff, 1'b0);
    add_sample(32'h8000_0000, 1'b0);
    add_sample(32'h0000_0000, 1'b0);
    add_sample(32'hffff_ffff, 1'b0);
    add_sample(32'h0000_0001, 1'b0);
    add_sample(32'h7fff_ffff, 1'b0);
    add_sample(32'h8000_0000, 1'b0);
    add_sample(32'h0000_0000, 1'b1);

    // Fill all cells in descending order; then new values are dropped, old ones counted.
    for (i = 0; i < svct_pkg::CELLS; i++) add_sample(32'(1000 - 7 * i), 1'b0);
    add_sample(32'(5000), 1'b0);
    add_sample(32'(-5000), 1'b0);
    add_sample(32'(1000), 1'b0);
    add_sample(32'(1000 - 7 * (svct_pkg::CELLS - 1)), 1'b0);
    add_sample(32'(77777), 1'b1);
    add_sample(32'(5), 1'b1, 1'b1);

    total = 0;
    while (total < 200) begin
      big = ($urandom_range(0, 19) == 0);
      len = big ? $urandom_range(60, 72) : $urandom_range(1, 10);
      hold = (total == 0) || ($urandom_range(0, 7) == 0);
      for (i = 0; i < len; i++) begin
        add_sample((big && $urandom_range(0, 5) != 0) ? $urandom() : pick_value(),
                   i == len - 1, hold && i == 0);
      end
      total += len;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (sample_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (table_due.size() != 0) @(posedge clk);
    repeat (svct_pkg::CELLS + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
